@@ rtl/core/frgcd_pkg.sv @@
// ----------------------------------------------------------------------------
// frgcd_pkg: shared types and constants for the fraction reducer
// Default data width and the sequencer state encoding.
// ----------------------------------------------------------------------------
package frgcd_pkg;

    // default operand width
    localparam int DATA_WIDTH_DEF = 32;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TWOS,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } state_t;

endpackage

@@ rtl/core/fraction_reduce_gcd.sv @@
// ----------------------------------------------------------------------------
// fraction_reduce_gcd: reduce a signed fraction to lowest terms
//
// Input channel (in_valid/in_ready) takes a numerator and a denominator.
// Output channel (out_valid/out_ready) returns the reduced numerator, the
// reduced denominator and a success flag, one result per item.
// When either operand is zero or negative, both values come back unchanged
// with success clear, passing straight from idle to the final state.
// Otherwise the greatest common divisor is found by binary GCD (common
// factors of two stripped first, then subtract-and-halve steps), and both
// operands are divided by its odd part with restoring division, one quotient
// bit per cycle. The GCD and division steps share one W+1 bit subtractor.
// Items are handled one at a time: in_ready is high only while the
// sequencer is idle. A finished result sits in the output register, so a
// new item can be taken while the receiver stalls; the sequencer holds in
// its final state only if a second result is ready before the first leaves.
// Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module fraction_reduce_gcd
    import frgcd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] numerator,
    input  logic signed [DATA_WIDTH-1:0] denominator,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] reduced_numerator,
    output logic signed [DATA_WIDTH-1:0] reduced_denominator,
    output logic                         success
);

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(DATA_WIDTH);

    // sequencer
    state_t state_reg, state_next;

    // datapath registers
    logic [W-1:0]     a_reg, a_next;
    logic [W-1:0]     b_reg, b_next;
    logic [W-1:0]     num_reg, num_next;
    logic [W-1:0]     den_reg, den_next;
    logic [W-1:0]     work_reg, work_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     res_num_reg, res_num_next;
    logic [W-1:0]     res_den_reg, res_den_next;
    logic             res_ok_reg, res_ok_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [W-1:0]     out_num_reg, out_num_next;
    logic [W-1:0]     out_den_reg, out_den_next;
    logic             out_ok_reg, out_ok_next;

    // shared subtractor
    logic [W-1:0] sub_x, sub_y;
    logic [W:0]   diff;
    logic [W-1:0] diff_neg;

    // status
    logic         in_fire;
    logic         both_pos;
    logic         any_odd;
    logic         ab_equal;
    logic         cnt_last;
    logic         out_free;
    logic [W-1:0] rem_shift;
    logic         qbit;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign both_pos = !numerator[W-1] && (numerator != '0)
                   && !denominator[W-1] && (denominator != '0);
    assign any_odd  = a_reg[0] || b_reg[0];
    assign cnt_last = (cnt_reg == CNT_W'(W - 1));
    assign out_free = !out_valid_reg || out_ready;

    // partial remainder with the next dividend bit shifted in
    assign rem_shift = {rem_reg[W-2:0], work_reg[W-1]};

    // operand select for the shared subtractor
    always_comb
    begin
        if ((state_reg == ST_DIVN) || (state_reg == ST_DIVD))
        begin
            sub_x = rem_shift;
            sub_y = a_reg;
        end
        else
        begin
            sub_x = a_reg;
            sub_y = b_reg;
        end
    end

    assign diff     = {1'b0, sub_x} - {1'b0, sub_y};
    assign diff_neg = W'(-diff);
    assign ab_equal = (diff == '0);
    assign qbit     = !diff[W];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = both_pos ? ST_TWOS : ST_DONE;
                end
            end
            ST_TWOS:
            begin
                if (any_odd)
                begin
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (ab_equal)
                begin
                    state_next = ST_DIVN;
                end
            end
            ST_DIVN:
            begin
                if (cnt_last)
                begin
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD:
            begin
                if (cnt_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        a_next       = a_reg;
        b_next       = b_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        res_ok_next  = res_ok_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    a_next       = numerator;
                    b_next       = denominator;
                    res_num_next = numerator;
                    res_den_next = denominator;
                    res_ok_next  = 1'b0;
                end
            end
            ST_TWOS:
            begin
                // strip common factors of two; the quotient is unchanged
                if (any_odd)
                begin
                    num_next = a_reg;
                    den_next = b_reg;
                end
                else
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                end
            end
            ST_GCD:
            begin
                // binary gcd step, gcd ends in a_reg
                if (ab_equal)
                begin
                    work_next = num_reg;
                    rem_next  = '0;
                    cnt_next  = '0;
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (!diff[W])
                begin
                    a_next = diff[W-1:0] >> 1;
                end
                else
                begin
                    b_next = diff_neg >> 1;
                end
            end
            ST_DIVN, ST_DIVD:
            begin
                // restoring division, one quotient bit per cycle
                rem_next  = qbit ? diff[W-1:0] : rem_shift;
                work_next = {work_reg[W-2:0], qbit};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_last)
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    if (state_reg == ST_DIVN)
                    begin
                        res_num_next = {work_reg[W-2:0], qbit};
                        work_next    = den_reg;
                    end
                    else
                    begin
                        res_den_next = {work_reg[W-2:0], qbit};
                        res_ok_next  = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;
        out_ok_next    = out_ok_reg;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
            out_num_next   = res_num_reg;
            out_den_next   = res_den_reg;
            out_ok_next    = res_ok_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        res_ok_reg  <= res_ok_next;
        out_num_reg <= out_num_next;
        out_den_reg <= out_den_next;
        out_ok_reg  <= out_ok_next;
    end

    assign out_valid           = out_valid_reg;
    assign reduced_numerator   = out_num_reg;
    assign reduced_denominator = out_den_reg;
    assign success             = out_ok_reg;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for fraction_reduce_gcd
// Directed corner fractions, a long output stall that backs up the input,
// then random fractions. Every result is compared field by field against
// an in-bench Euclid predictor, in order of acceptance.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int W              = frgcd_pkg::DATA_WIDTH_DEF;
    localparam int MAX_LATENCY    = 5 * W + 2;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 400;

    typedef logic signed [W-1:0] operand_t;
    typedef logic [W-1:0]        magnitude_t;

    localparam operand_t OP_MAX = {1'b0, {(W-1){1'b1}}};
    localparam operand_t OP_MIN = {1'b1, {(W-1){1'b0}}};

    // one expected result
    typedef struct packed {
        operand_t num;
        operand_t den;
        logic     ok;
    } fraction_t;

    // shapes of random fractions
    typedef enum int {
        MIX_RAW,
        MIX_POSITIVE,
        MIX_COMMON,
        MIX_POW2,
        MIX_NONPOS
    } mix_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    operand_t numerator;
    operand_t denominator;
    logic     out_valid;
    logic     out_ready;
    operand_t reduced_numerator;
    operand_t reduced_denominator;
    logic     success;

    fraction_t pending_fractions[$];
    int        fail_count;
    bit        idling_on;
    int        holdoff_len;

    fraction_reduce_gcd #(
        .DATA_WIDTH (W)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .numerator           (numerator),
        .denominator         (denominator),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .reduced_numerator   (reduced_numerator),
        .reduced_denominator (reduced_denominator),
        .success             (success)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // lowest terms by euclid, inputs echoed when either is not positive
    function automatic fraction_t reduce_fraction(operand_t n, operand_t d);
        fraction_t  r;
        magnitude_t a;
        magnitude_t b;
        magnitude_t t;
        if (n <= 0 || d <= 0)
        begin
            r.num = n;
            r.den = d;
            r.ok  = 1'b0;
        end
        else
        begin
            a = magnitude_t'(n);
            b = magnitude_t'(d);
            while (b != 0)
            begin
                t = a % b;
                a = b;
                b = t;
            end
            r.num = operand_t'(magnitude_t'(n) / a);
            r.den = operand_t'(magnitude_t'(d) / a);
            r.ok  = 1'b1;
        end
        return r;
    endfunction

    // offer one fraction and wait until it is taken
    task automatic offer_fraction(operand_t n, operand_t d);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        numerator   <= n;
        denominator <= d;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        pending_fractions.push_back(reduce_fraction(n, d));
        @(negedge clk);
    endtask

    // result side: long hold-off on request, random stall bursts otherwise
    always
    begin
        @(negedge clk);
        if (holdoff_len > 0)
        begin
            out_ready <= 1'b0;
            repeat (holdoff_len) @(negedge clk);
            holdoff_len = 0;
        end
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        out_ready <= 1'b1;
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        fraction_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_fractions.size() == 0)
            begin
                $error("unexpected result: num %h den %h success %b",
                       reduced_numerator, reduced_denominator, success);
                fail_count++;
            end
            else
            begin
                want = pending_fractions.pop_front();
                if (reduced_numerator !== want.num)
                begin
                    $error("reduced_numerator: expected %h actual %h",
                           want.num, reduced_numerator);
                    fail_count++;
                end
                if (reduced_denominator !== want.den)
                begin
                    $error("reduced_denominator: expected %h actual %h",
                           want.den, reduced_denominator);
                    fail_count++;
                end
                if (success !== want.ok)
                begin
                    $error("success: expected %b actual %b", want.ok, success);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("fraction_reduce_gcd regression: fail");
        $finish;
    end

    // corner fractions: extremes, zero and negative operands, known gcds
    task automatic test_directed();
        idling_on = 1'b1;
        offer_fraction(1, 1);
        offer_fraction(0, 0);
        offer_fraction(0, 5);
        offer_fraction(5, 0);
        offer_fraction(-1, 5);
        offer_fraction(5, -1);
        offer_fraction(-1, -1);
        offer_fraction(OP_MIN, OP_MIN);
        offer_fraction(OP_MIN, 1);
        offer_fraction(1, OP_MIN);
        offer_fraction(OP_MAX, OP_MIN);
        offer_fraction(OP_MIN, OP_MAX);
        offer_fraction(OP_MAX, OP_MAX);
        offer_fraction(OP_MAX, 1);
        offer_fraction(1, OP_MAX);
        offer_fraction(OP_MAX, OP_MAX - 1);
        offer_fraction(OP_MAX - 1, OP_MAX >>> 1);
        offer_fraction(12, 18);
        offer_fraction(6, 4);
        offer_fraction(7, 13);
        offer_fraction(operand_t'(1) <<< 30, operand_t'(1) <<< 20);
        offer_fraction(operand_t'(1) <<< 30, OP_MAX - 1);
        offer_fraction(360 * 1024, 84 * 4096);
        offer_fraction(OP_MAX - 2, 3);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_output_holdoff();
        idling_on   = 1'b0;
        holdoff_len = HOLDOFF_CYCLES;
        for (int i = 0; i < 8; i++)
        begin
            offer_fraction(operand_t'($urandom) & OP_MAX | 1,
                           operand_t'($urandom_range(1, 1000)) * 6);
        end
    endtask

    // random fractions, mostly positive with shared factors
    task automatic test_random_fractions();
        mix_t            mix;
        operand_t        n;
        operand_t        d;
        longint unsigned g;
        longint unsigned lim;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // idle stretches alternate with clean ones, none near the end
            idling_on = (i < RANDOM_ITEMS - 60) && ((i / 50) % 3 != 2);
            mix = mix_t'($urandom_range(0, 19) / 4);
            if ($urandom_range(0, 9) < 3)
                mix = MIX_COMMON;
            case (mix)
                MIX_RAW:
                begin
                    n = operand_t'($urandom);
                    d = operand_t'($urandom);
                end
                MIX_POSITIVE:
                begin
                    n = operand_t'($urandom) & OP_MAX;
                    d = operand_t'($urandom) & OP_MAX;
                    if (n == 0) n = 1;
                    if (d == 0) d = 1;
                end
                MIX_COMMON:
                begin
                    g   = longint'($urandom_range(1, 65535)) << $urandom_range(0, 12);
                    lim = longint'(OP_MAX) / g;
                    n   = operand_t'(g * $urandom_range(1, int'(lim)));
                    d   = operand_t'(g * $urandom_range(1, int'(lim)));
                end
                MIX_POW2:
                begin
                    n = operand_t'($urandom_range(1, 65535) | 1) <<< $urandom_range(0, 15);
                    d = operand_t'($urandom_range(1, 65535) | 1) <<< $urandom_range(0, 15);
                end
                default:
                begin
                    // one operand zero or negative, the other positive
                    n = operand_t'($urandom) & OP_MAX | 1;
                    case ($urandom_range(0, 2))
                        0: d = 0;
                        1: d = OP_MIN;
                        default: d = -operand_t'($urandom_range(1, 100000));
                    endcase
                    if ($urandom_range(0, 1))
                    begin
                        g = longint'(n);
                        n = d;
                        d = operand_t'(g);
                    end
                end
            endcase
            offer_fraction(n, d);
        end
    endtask

    // sequence of tests
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        numerator   = '0;
        denominator = '0;
        out_ready   = 1'b0;
        fail_count  = 0;
        idling_on   = 1'b0;
        holdoff_len = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_output_holdoff();
        test_random_fractions();
        in_valid <= 1'b0;

        // drain, then let any late result show up
        while (pending_fractions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (MAX_LATENCY) @(posedge clk);

        if (fail_count == 0)
            $display("fraction_reduce_gcd regression: pass");
        else
            $display("fraction_reduce_gcd regression: fail");
        $finish;
    end

endmodule

@@ fraction_reduce_gcd.f @@
rtl/core/frgcd_pkg.sv
rtl/core/fraction_reduce_gcd.sv
dv/tb_top.sv
